[rtl/lmss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lmss_pkg
// Types and constants shared by the scrolling pixel store.
// ----------------------------------------------------------------------------
package lmss_pkg;

  localparam int GLYPH_W    = 5;
  localparam int GLYPH_H    = 5;
  localparam int WORD_W     = 16;
  localparam int GWIDTH_W   = 3;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [WORD_W-1:0] BLANK_WORD_RST = 16'hFFE0;

  localparam logic [APB_ADDR_W-1:0] REG_BLANK_WORD = 2'd0;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [GLYPH_W*GLYPH_H-1:0]   glyph_bits;
    logic [3:0]                   rotate_count;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]   drive_word;
    logic [GWIDTH_W-1:0] glyph_width;
    logic                last_word;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_LAST
  } state_t;

endpackage
`default_nettype wire

[rtl/led_matrix_scroll_store_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_scroll_store_core
// Pixel store for a scrolling text display: rotate, glyph insert, clear of
// the last column and frame render, one row per cycle through a row memory.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------
// command  | start / busy           | cmd (opcode, glyph_bits, rotate_count)
// result   | result_valid strobe    | result (drive_word, glyph_width, last)
// config   | APB psel/penable/...   | blank_word at byte address 0
//
// Each command walks the row memory, one read per row and, but for render, one write-back per row.
// Rotate and clear end after the last row; insert and render add a final S_LAST beat.
// Render beats come out one per cycle, ROWS row words then the blank word.
// Reset clears the row valid bits; a row never written reads as all off.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module led_matrix_scroll_store_core #(
  parameter int ROWS         = 5,
  parameter int VISIBLE_COLS = 11,
  parameter int SPARE_COLS   = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire lmss_pkg::cmd_t                      cmd,
  output      logic                                busy,
  output      logic                                result_valid,
  output      lmss_pkg::result_t                   result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lmss_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lmss_pkg::APB_DATA_W-1:0]     pwdata,
  output      logic [lmss_pkg::APB_DATA_W-1:0]     prdata,
  output      logic                                pready
);
  import lmss_pkg::*;

  localparam int TOTAL = VISIBLE_COLS + SPARE_COLS;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(ROWS + 1);
  localparam int TW    = $clog2(TOTAL);

  logic [TOTAL-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld;

  state_t state, state_next;
  logic [CW-1:0]             cnt;
  logic                      proc_valid;
  logic [AW-1:0]             proc_row;
  logic [1:0]                op_q;
  logic [GLYPH_W*GLYPH_H-1:0] glyph_q;
  logic [GWIDTH_W-1:0]       width_q;
  logic [TW-1:0]             rot_q;
  logic [TOTAL-1:0]          rd_data;
  logic                      rd_vld_q;
  logic [WORD_W-1:0]         blank_word;

  logic                      accept;
  logic                      rd_en;
  logic                      mem_we;
  logic                      last_row;
  logic [GWIDTH_W-1:0]       width_calc;
  logic [TW-1:0]             rot_calc;
  logic [TOTAL-1:0]          row_cur;
  logic [TOTAL-1:0]          rot_row;
  logic [TOTAL-1:0]          new_row;
  logic [WORD_W-1:0]         render_word;
  logic                      res_valid_next;
  result_t                   res_next;
  logic                      cfg_we;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_BLANK_WORD);
  assign prdata = (paddr == REG_BLANK_WORD) ? APB_DATA_W'(blank_word) : '0;

  // glyph width and rotate amount, worked out at accept
  always_comb begin
    logic [GLYPH_W-1:0] orv;
    logic [4:0]         amt;
    orv        = '0;
    width_calc = GWIDTH_W'(1);
    for (int i = 0; i < GLYPH_H; i++) begin
      orv = orv | cmd.glyph_bits[(GLYPH_H-1-i)*GLYPH_W +: GLYPH_W];
    end
    for (int j = 0; j < GLYPH_W; j++) begin
      if (orv[j]) begin
        width_calc = GWIDTH_W'(j + 1);
      end
    end
    case (cmd.opcode)
      OP_INSERT: amt = 5'(width_calc);
      OP_ROTATE: amt = 5'(cmd.rotate_count);
      default:   amt = '0;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (amt >= 5'(TOTAL)) begin
        amt = amt - 5'(TOTAL);
      end
    end
    rot_calc = TW'(amt);
  end

  // row modify
  always_comb begin
    logic [2*TOTAL-1:0] dbl;
    logic [GLYPH_W-1:0] g;
    row_cur = rd_vld_q ? rd_data : '0;
    dbl     = {row_cur, row_cur} >> rot_q;
    rot_row = dbl[TOTAL-1:0];
    g       = '0;
    for (int i = 0; i < GLYPH_H; i++) begin
      if (int'(proc_row) == i) begin
        g = glyph_q[(GLYPH_H-1-i)*GLYPH_W +: GLYPH_W];
      end
    end
    new_row = rot_row;
    case (op_q)
      OP_INSERT: begin
        if (int'(proc_row) < GLYPH_H) begin
          for (int c = 0; c < GLYPH_W; c++) begin
            if ((VISIBLE_COLS - 1 + c < TOTAL) && (GLYPH_W - c <= int'(width_q))) begin
              new_row[VISIBLE_COLS-1+c] = g[GLYPH_W-1-c];
            end
          end
        end
      end
      OP_CLEAR: new_row[TOTAL-1] = 1'b0;
      default:  new_row = rot_row;
    endcase
  end

  // render word, same bit order as the store scan
  always_comb begin
    logic [WORD_W-1:0] rb;
    rb          = WORD_W'(1) << (ROWS - 1 - int'(proc_row));
    render_word = blank_word;
    for (int j = 0; j < VISIBLE_COLS; j++) begin
      if (row_cur[j]) begin
        render_word          = render_word | rb;
        render_word[15 - j]  = 1'b0;
      end
    end
  end

  assign last_row = proc_valid && (proc_row == AW'(ROWS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RUN;
      S_RUN: begin
        if (last_row) begin
          state_next = (op_q == OP_INSERT || op_q == OP_RENDER) ? S_LAST : S_IDLE;
        end
      end
      S_LAST:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = (state != S_IDLE);
    rd_en          = (state == S_RUN) && (cnt < CW'(ROWS));
    mem_we         = proc_valid && (op_q != OP_RENDER);
    res_valid_next = 1'b0;
    res_next       = '0;
    unique case (state)
      S_RUN: begin
        if (proc_valid && op_q == OP_RENDER) begin
          res_valid_next      = 1'b1;
          res_next.drive_word = render_word;
        end
      end
      S_LAST: begin
        res_valid_next     = 1'b1;
        res_next.last_word = 1'b1;
        if (op_q == OP_INSERT) begin
          res_next.glyph_width = width_q;
        end else begin
          res_next.drive_word = blank_word;
        end
      end
      default: res_valid_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[cnt[AW-1:0]];
      rd_vld_q <= row_vld[cnt[AW-1:0]];
    end
    if (mem_we) begin
      mem[proc_row] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= cmd.opcode;
      glyph_q <= cmd.glyph_bits;
      width_q <= width_calc;
      rot_q   <= rot_calc;
    end
    proc_row <= cnt[AW-1:0];
    result   <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      proc_valid   <= 1'b0;
      row_vld      <= '0;
      result_valid <= 1'b0;
      blank_word   <= BLANK_WORD_RST;
    end else begin
      state        <= state_next;
      proc_valid   <= rd_en;
      result_valid <= res_valid_next;
      if (accept) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + CW'(1);
      end
      if (mem_we) begin
        row_vld[proc_row] <= 1'b1;
      end
      if (cfg_we) begin
        blank_word <= pwdata[WORD_W-1:0];
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_idle_no_proc: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !proc_valid)
    else $error("row processed while idle");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_word |=> !result_valid)
    else $error("beat right after final beat");

  a_render_width: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_word |-> result.glyph_width == '0)
    else $error("row word with nonzero glyph width");

  a_no_render_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_RUN && op_q != OP_RENDER)
    else $error("store written outside a modifying command");

endmodule
`default_nettype wire
